// File: src/ifd_pkg.sv
// Shared types and constants for the USB interface descriptor finder.
package ifd_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WANT_CLASS    = 3'd0,
    REG_WANT_SUBCLASS = 3'd1,
    REG_WANT_PROTOCOL = 3'd2,
    REG_WANT_ALT      = 3'd3,
    REG_IGNORE_MASK   = 3'd4,
    REG_RESUME_OFFSET = 3'd5
  } cfg_idx_t;

  // Bits of the ignore mask; a one disables that compare.
  localparam int IGN_CLASS    = 0;
  localparam int IGN_SUBCLASS = 1;
  localparam int IGN_PROTOCOL = 2;
  localparam int IGN_ALT      = 3;
  localparam logic [3:0] IGNORE_MASK_RST = 4'hF;

  // Descriptor constants.
  localparam logic [7:0]  INTF_DESC_TYPE    = 8'd4;
  localparam logic [7:0]  INTF_DESC_MIN_LEN = 8'd9;
  localparam logic [7:0]  MIN_DESC_LEN      = 8'd2;
  localparam logic [16:0] EARLY_JUDGE_POS   = 17'd3;
  localparam logic [15:0] POS_MAX           = 16'hFFFF;

  // Captured interface bytes, bytes 2..7 of the descriptor.
  localparam int CAP_COUNT = 6;
  localparam int CAP_NUM   = 0;
  localparam int CAP_ALT   = 1;
  localparam int CAP_EPS   = 2;
  localparam int CAP_CLASS = 3;
  localparam int CAP_SUB   = 4;
  localparam int CAP_PROTO = 5;

  // Result status codes.
  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0]  want_class;
    logic [7:0]  want_subclass;
    logic [7:0]  want_protocol;
    logic [7:0]  want_alt;
    logic [3:0]  ignore_mask;
    logic [15:0] resume_offset;
  } cfg_t;

  // One result beat from the walker.
  typedef struct packed {
    logic        valid;
    logic        status;
    logic [15:0] desc_offset;
    logic [7:0]  intf_number;
    logic [7:0]  alt_setting;
    logic [7:0]  num_endpoints;
    logic [7:0]  intf_class;
    logic [7:0]  intf_subclass;
    logic [7:0]  intf_protocol;
  } result_t;

endpackage

// File: src/ifd_cfg_regs.sv
// Configuration register file of the interface descriptor finder.
module ifd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ifd_pkg::cfg_t                 cfg
);
  import ifd_pkg::*;

  cfg_t cfg_r;

  // Register writes; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.want_class    <= '0;
      cfg_r.want_subclass <= '0;
      cfg_r.want_protocol <= '0;
      cfg_r.want_alt      <= '0;
      cfg_r.ignore_mask   <= IGNORE_MASK_RST;
      cfg_r.resume_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_WANT_CLASS:    cfg_r.want_class    <= cfg_wdata[7:0];
        REG_WANT_SUBCLASS: cfg_r.want_subclass <= cfg_wdata[7:0];
        REG_WANT_PROTOCOL: cfg_r.want_protocol <= cfg_wdata[7:0];
        REG_WANT_ALT:      cfg_r.want_alt      <= cfg_wdata[7:0];
        REG_IGNORE_MASK:   cfg_r.ignore_mask   <= cfg_wdata[3:0];
        REG_RESUME_OFFSET: cfg_r.resume_offset <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/ifd_walker.sv
// Descriptor walker: per-byte header tracking, interface capture and match.
module ifd_walker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  ifd_pkg::cfg_t    cfg,
  output ifd_pkg::result_t result
);
  import ifd_pkg::*;

  logic [15:0] pos_r,      pos_nxt;
  logic [15:0] total_r,    total_nxt;
  logic [16:0] next_pos_r, next_pos_nxt;
  logic [15:0] start_r,    start_nxt;
  logic [7:0]  len_r,      len_nxt;
  logic [7:0]  type_r,     type_nxt;
  logic        done_r,     done_nxt;
  logic        stopped_r,  stopped_nxt;
  logic        hdr_r,      hdr_nxt;
  logic        intf_r,     intf_nxt;
  logic [7:0]  cap_r   [CAP_COUNT];
  logic [7:0]  cap_nxt [CAP_COUNT];

  // Next-state logic for one accepted byte.
  always_comb begin
    logic [16:0] pos17;
    logic [16:0] due;
    logic [16:0] off17;
    logic [16:0] rel;
    logic [2:0]  cap_idx;
    logic        match;

    pos_nxt      = pos_r;
    total_nxt    = total_r;
    next_pos_nxt = next_pos_r;
    start_nxt    = start_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    done_nxt     = done_r;
    stopped_nxt  = stopped_r;
    hdr_nxt      = hdr_r;
    intf_nxt     = intf_r;
    cap_nxt      = cap_r;
    result       = '0;

    pos17   = {1'b0, pos_r};
    off17   = {1'b0, start_r};
    due     = off17 + 17'd1;
    rel     = pos17 - off17;
    cap_idx = rel[2:0] - 3'd2;
    match   = 1'b0;

    if (!done_r) begin
      // Configuration header: first descriptor offset and total length.
      if (pos_r == 16'd0) next_pos_nxt = {9'd0, data_byte};
      if (pos_r == 16'd2) total_nxt[7:0]  = data_byte;
      if (pos_r == 16'd3) total_nxt[15:8] = data_byte;

      if (!stopped_r) begin
        // Header judgment; early headers wait for the total length.
        if (hdr_r) begin
          if (pos17 == due) type_nxt = data_byte;
          if (due < EARLY_JUDGE_POS) due = EARLY_JUDGE_POS;
          if (pos17 == due) begin
            hdr_nxt = 1'b0;
            if ((off17 + 17'd2 > {1'b0, total_nxt}) || (len_r < MIN_DESC_LEN) ||
                (off17 + {9'd0, len_r} > {1'b0, total_nxt})) begin
              stopped_nxt = 1'b1;
            end else begin
              next_pos_nxt = off17 + {9'd0, len_r};
              if ((type_nxt == INTF_DESC_TYPE) && (len_r >= INTF_DESC_MIN_LEN) &&
                  (start_r >= cfg.resume_offset)) begin
                intf_nxt = 1'b1;
              end
            end
          end
        end

        // Capture interface bytes 2..7 and compare at byte 7.
        if (intf_nxt && (pos17 >= off17 + 17'd2)) begin
          if (rel <= 17'd7) begin
            for (int k = 0; k < CAP_COUNT; k++) begin
              if (cap_idx == 3'(k)) cap_nxt[k] = data_byte;
            end
          end
          if (rel == 17'd7) begin
            intf_nxt = 1'b0;
            match = (cfg.ignore_mask[IGN_CLASS] ||
                     (cap_nxt[CAP_CLASS] == cfg.want_class)) &&
                    (cfg.ignore_mask[IGN_SUBCLASS] ||
                     (cap_nxt[CAP_SUB] == cfg.want_subclass)) &&
                    (cfg.ignore_mask[IGN_PROTOCOL] ||
                     (cap_nxt[CAP_PROTO] == cfg.want_protocol)) &&
                    (cfg.ignore_mask[IGN_ALT] ||
                     (cap_nxt[CAP_ALT] == cfg.want_alt));
            if (match) begin
              done_nxt             = 1'b1;
              result.valid         = 1'b1;
              result.status        = STATUS_FOUND;
              result.desc_offset   = start_r;
              result.intf_number   = cap_nxt[CAP_NUM];
              result.alt_setting   = cap_nxt[CAP_ALT];
              result.num_endpoints = cap_nxt[CAP_EPS];
              result.intf_class    = cap_nxt[CAP_CLASS];
              result.intf_subclass = cap_nxt[CAP_SUB];
              result.intf_protocol = cap_nxt[CAP_PROTO];
            end
          end
        end

        // Start of the next descriptor header.
        if (!done_nxt && !stopped_nxt && !hdr_nxt && !intf_nxt &&
            (pos17 == next_pos_nxt)) begin
          start_nxt = pos_r;
          len_nxt   = data_byte;
          hdr_nxt   = 1'b1;
        end
      end

      if (pos_r != POS_MAX) pos_nxt = pos_r + 16'd1;
    end

    // End of set: report not-found if needed, then clear the stream.
    if (last_byte) begin
      if (!done_nxt) begin
        result        = '0;
        result.valid  = 1'b1;
        result.status = STATUS_NOT_FOUND;
      end
      pos_nxt      = '0;
      total_nxt    = '0;
      next_pos_nxt = '0;
      start_nxt    = '0;
      len_nxt      = '0;
      type_nxt     = '0;
      done_nxt     = 1'b0;
      stopped_nxt  = 1'b0;
      hdr_nxt      = 1'b0;
      intf_nxt     = 1'b0;
      for (int k = 0; k < CAP_COUNT; k++) cap_nxt[k] = '0;
    end
  end

  // Walk state; it advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      total_r    <= '0;
      next_pos_r <= '0;
      start_r    <= '0;
      len_r      <= '0;
      type_r     <= '0;
      done_r     <= 1'b0;
      stopped_r  <= 1'b0;
      hdr_r      <= 1'b0;
      intf_r     <= 1'b0;
      for (int k = 0; k < CAP_COUNT; k++) cap_r[k] <= '0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      next_pos_r <= next_pos_nxt;
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      type_r     <= type_nxt;
      done_r     <= done_nxt;
      stopped_r  <= stopped_nxt;
      hdr_r      <= hdr_nxt;
      intf_r     <= intf_nxt;
      cap_r      <= cap_nxt;
    end
  end

endmodule

// File: src/ifd_out_stage.sv
// Result register between the walker and the output channel.
module ifd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ifd_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready,
  output ifd_pkg::result_t out_data
);
  import ifd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;
  logic    load;

  // A new byte is taken whenever the result register is empty or draining.
  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready && result.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: src/usb_interface_descriptor_finder_top.sv
// Top level of the USB interface descriptor finder.
//
// Input channel: one byte of a configuration descriptor set per beat
// (in_data_byte, with in_last_byte on the final byte of the set).
// Output channel: at most one result beat per set, either the first
// interface descriptor that matches the configured class, subclass,
// protocol and alternate setting (status 0), or not-found (status 1)
// on the last byte. Configuration registers are written through the
// cfg_ port only while no set is in flight, a rule for the user that
// the block does not enforce. Throughput: one byte per cycle unless
// stalled, set by the walker step that updates the header and capture
// state for each accepted byte. The result beat is registered and
// valid in the cycle after the byte that completes it (byte 7 of the
// matching descriptor or the last byte). Reset: registers return to
// their defaults (ignore mask all ones) and the stream state clears,
// so the next byte is offset 0 of a new set. Stall: while a result
// waits in the output register and out_ready is low, in_ready drops;
// when it is taken, a new byte is accepted in the same cycle.
module usb_interface_descriptor_finder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [15:0]                   out_desc_offset,
  output logic [7:0]                    out_intf_number,
  output logic [7:0]                    out_alt_setting,
  output logic [7:0]                    out_num_endpoints,
  output logic [7:0]                    out_intf_class,
  output logic [7:0]                    out_intf_subclass,
  output logic [7:0]                    out_intf_protocol
);
  import ifd_pkg::*;

  cfg_t    cfg;
  result_t walk_res;
  result_t out_data;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  ifd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifd_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg),
    .result    (walk_res)
  );

  ifd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .result    (walk_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status        = out_data.status;
  assign out_desc_offset   = out_data.desc_offset;
  assign out_intf_number   = out_data.intf_number;
  assign out_alt_setting   = out_data.alt_setting;
  assign out_num_endpoints = out_data.num_endpoints;
  assign out_intf_class    = out_data.intf_class;
  assign out_intf_subclass = out_data.intf_subclass;
  assign out_intf_protocol = out_data.intf_protocol;

`ifndef SYNTH
  // A found descriptor never starts below the resume offset.
  a_found_after_resume: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_FOUND)) |-> (out_desc_offset >= cfg.resume_offset))
    else $error("found descriptor lies below resume offset");

  // A found descriptor honors the class compare unless it is masked.
  a_found_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_FOUND) && !cfg.ignore_mask[IGN_CLASS])
      |-> (out_intf_class == cfg.want_class))
    else $error("found descriptor class mismatch");

  // A not-found beat carries zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_NOT_FOUND))
      |-> ((out_desc_offset == 16'd0) && (out_intf_number == 8'd0) &&
           (out_intf_class == 8'd0) && (out_alt_setting == 8'd0)))
    else $error("not-found beat carries nonzero fields");
`endif

endmodule
